// ===== src/base64_decoder_core_macros.svh =====
// Assertion macros shared by the base64 decoder RTL.
`ifndef BASE64_DECODER_CORE_MACROS_SVH
`define BASE64_DECODER_CORE_MACROS_SVH
`ifndef SYNTH
`define B64D_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
`define B64D_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define B64D_ASSERT(lbl, clk, rst, prop, msg)
`define B64D_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

// ===== src/b64d_pkg.sv =====
// Types, constants and the alphabet lookup of the base64 decoder.
`default_nettype none
package b64d_pkg;

   localparam logic [7:0] UPPER_FIRST = 8'h41;
   localparam logic [7:0] UPPER_LAST  = 8'h5A;
   localparam logic [7:0] LOWER_FIRST = 8'h61;
   localparam logic [7:0] LOWER_LAST  = 8'h7A;
   localparam logic [7:0] DIGIT_FIRST = 8'h30;
   localparam logic [7:0] DIGIT_LAST  = 8'h39;
   localparam logic [7:0] PLUS_CHAR   = 8'h2B;
   localparam logic [7:0] SLASH_CHAR  = 8'h2F;
   localparam logic [5:0] LOWER_BASE  = 6'd26;
   localparam logic [5:0] DIGIT_BASE  = 6'd52;
   localparam logic [5:0] PLUS_CODE   = 6'd62;
   localparam logic [5:0] SLASH_CODE  = 6'd63;

   typedef struct packed {
      logic       valid;
      logic [5:0] value;
   } sextet_type;

   typedef struct packed {
      logic [2:0][7:0] bytes;
      logic [1:0]      count;
      logic            is_end;
   } job_type;

   function automatic sextet_type sextet_of(input logic [7:0] c);
      sextet_type s;
      s.valid = 1'b1;
      s.value = '0;
      unique case (c) inside
         [UPPER_FIRST:UPPER_LAST]: s.value = 6'(c - UPPER_FIRST);
         [LOWER_FIRST:LOWER_LAST]: s.value = 6'(c - LOWER_FIRST) + LOWER_BASE;
         [DIGIT_FIRST:DIGIT_LAST]: s.value = 6'(c - DIGIT_FIRST) + DIGIT_BASE;
         PLUS_CHAR:                s.value = PLUS_CODE;
         SLASH_CHAR:               s.value = SLASH_CODE;
         default:                  s.valid = 1'b0;
      endcase
      return s;
   endfunction

endpackage
`default_nettype wire

// ===== src/b64d_req_if.sv =====
// Input channel interface: one text character per beat.
`default_nettype none
interface b64d_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] text_char;
   logic       end_of_text;

   modport source (output valid, output text_char, output end_of_text, input ready);
   modport sink (input valid, input text_char, input end_of_text, output ready);
endinterface
`default_nettype wire

// ===== src/b64d_rsp_if.sv =====
// Result channel interface: one decoded byte or end marker per beat.
`default_nettype none
interface b64d_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       has_data;
   logic       run_last;
   logic       stream_done;

   modport source (output valid, output data_byte, output has_data, output run_last,
                   output stream_done, input ready);
   modport sink (input valid, input data_byte, input has_data, input run_last,
                 input stream_done, output ready);
endinterface
`default_nettype wire

// ===== src/b64d_front.sv =====
// Front end: character lookup, group assembly and job generation.
`default_nettype none
module b64d_front (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            accept,
   input  wire logic [7:0]      text_char,
   input  wire logic            end_of_text,
   output b64d_pkg::job_type    job,
   output logic                 push
);

   logic [2:0][5:0] store_ff, store_in;
   logic [1:0]      count_ff, count_in;
   logic            halted_ff, halted_in;

   b64d_pkg::sextet_type sx;
   logic [1:0]           cnt;
   logic [1:0]           n;
   logic [2:0][7:0]      bytes;

   always_comb begin
      sx       = b64d_pkg::sextet_of(text_char);
      store_in = store_ff;
      cnt      = count_ff;
      halted_in = halted_ff;
      n        = 2'd0;
      bytes    = '0;
      if (!halted_ff) begin
         if (sx.valid) begin
            if (count_ff == 2'd3) begin
               bytes[0] = {store_ff[0], store_ff[1][5:4]};
               bytes[1] = {store_ff[1][3:0], store_ff[2][5:2]};
               bytes[2] = {store_ff[2][1:0], sx.value};
               n        = 2'd3;
               cnt      = 2'd0;
            end else begin
               store_in[count_ff] = sx.value;
               cnt = count_ff + 2'd1;
            end
         end else begin
            halted_in = 1'b1;
         end
      end
      if ((halted_in && !halted_ff) || end_of_text) begin
         if (cnt >= 2'd2) begin
            bytes[0] = {store_in[0], store_in[1][5:4]};
            n = 2'd1;
         end
         if (cnt == 2'd3) begin
            bytes[1] = {store_in[1][3:0], store_in[2][5:2]};
            n = 2'd2;
         end
         cnt = 2'd0;
      end
      if (end_of_text) begin
         halted_in = 1'b0;
      end
      count_in   = cnt;
      job.bytes  = bytes;
      job.count  = n;
      job.is_end = end_of_text;
      push       = accept && ((n != 2'd0) || end_of_text);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= 2'd0;
         halted_ff <= 1'b0;
      end else if (accept) begin
         count_ff  <= count_in;
         halted_ff <= halted_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         store_ff <= store_in;
      end
   end

endmodule
`default_nettype wire

// ===== src/b64d_queue.sv =====
// Job queue between the front end and the beat sequencer.
`default_nettype none
`include "base64_decoder_core_macros.svh"
module b64d_queue #(
   parameter int DEPTH = 4
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              push,
   input  wire b64d_pkg::job_type push_job,
   input  wire logic              pop,
   output b64d_pkg::job_type      head_job,
   output logic                   empty,
   output logic                   full
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

   b64d_pkg::job_type slots_ff [DEPTH];
   logic [PTR_W-1:0]  wr_ff, wr_in, rd_ff, rd_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;

   assign empty    = (cnt_ff == '0);
   assign full     = (cnt_ff == FULL_CNT);
   assign head_job = slots_ff[rd_ff];

   always_comb begin
      wr_in  = wr_ff;
      rd_in  = rd_ff;
      cnt_in = cnt_ff;
      if (push) begin
         wr_in = (wr_ff == LAST_PTR) ? '0 : wr_ff + PTR_W'(1);
      end
      if (pop) begin
         rd_in = (rd_ff == LAST_PTR) ? '0 : rd_ff + PTR_W'(1);
      end
      if (push && !pop) begin
         cnt_in = cnt_ff + CNT_W'(1);
      end else if (pop && !push) begin
         cnt_in = cnt_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slots_ff[wr_ff] <= push_job;
      end
   end

   `B64D_ASSERT(a_no_overflow, clock, reset, !(push && full && !pop), "push into full queue")
   `B64D_ASSERT(a_no_underflow, clock, reset, !(pop && empty), "pop from empty queue")
   `B64D_ASSERT(a_count_step, clock, reset, (!$past(reset) && $past(push) && !$past(pop)) |-> (cnt_ff == $past(cnt_ff) + CNT_W'(1)), "queue count did not advance on push")
   `B64D_ASSERT_ALWAYS(a_reset_empty, clock, $past(reset) |-> empty, "queue not empty after reset")

endmodule
`default_nettype wire

// ===== src/b64d_back.sv =====
// Back end: splits each job into result beats.
`default_nettype none
`include "base64_decoder_core_macros.svh"
module b64d_back (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire b64d_pkg::job_type head_job,
   input  wire logic              empty,
   output logic                   pop,
   b64d_rsp_if.source             rsp_bus
);

   logic [1:0] idx_ff, idx_in;
   logic       marker;
   logic       last;
   logic       beat;

   always_comb begin
      marker = (head_job.count == 2'd0);
      last   = marker || (idx_ff == (head_job.count - 2'd1));
      beat   = rsp_bus.valid && rsp_bus.ready;
      pop    = beat && last;
      idx_in = idx_ff;
      if (beat) begin
         idx_in = last ? 2'd0 : idx_ff + 2'd1;
      end
   end

   always_comb begin
      rsp_bus.valid       = !empty;
      rsp_bus.has_data    = !marker;
      rsp_bus.run_last    = last;
      rsp_bus.stream_done = last && head_job.is_end;
      case (idx_ff)
         2'd0:    rsp_bus.data_byte = head_job.bytes[0];
         2'd1:    rsp_bus.data_byte = head_job.bytes[1];
         default: rsp_bus.data_byte = head_job.bytes[2];
      endcase
      if (marker) begin
         rsp_bus.data_byte = 8'h00;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff <= 2'd0;
      end else begin
         idx_ff <= idx_in;
      end
   end

   `B64D_ASSERT(a_idx_in_range, clock, reset, !rsp_bus.valid || marker || (idx_ff < head_job.count), "beat index beyond job")
   `B64D_ASSERT(a_done_implies_last, clock, reset, !rsp_bus.valid || !rsp_bus.stream_done || rsp_bus.run_last, "stream end without item end")
   `B64D_ASSERT(a_idx_zero_when_empty, clock, reset, empty |-> (idx_ff == 2'd0), "beat index left over with no job")

endmodule
`default_nettype wire

// ===== src/base64_decoder_core.sv =====
// Top level of the streaming base64 decoder.
//
// The req_bus channel takes one character per beat, with end_of_text set on
// the last character of a stream. The rsp_bus channel gives one decoded byte
// per beat, or an end marker with has_data low when the end character makes
// no byte. run_last flags the last beat caused by a character, and
// stream_done flags the final beat of a stream.
// A character is accepted in every cycle while the job queue has room. Each
// character makes zero to three result beats, shown once its job heads the
// queue; the output side moves one beat per cycle while rsp_bus.ready is
// high, so a completed four-character group yields three output beats.
// The QUEUE_DEPTH-entry job queue parts the two sides. When the receiver
// stalls, beats hold steady and characters are still taken until the queue
// fills; req_bus.ready then drops.
// Synchronous reset empties the queue, clears the group count and resumes
// decoding; no beat is offered once reset has been sampled.
`default_nettype none
module base64_decoder_core #(
   parameter int QUEUE_DEPTH = 4
) (
   input  wire logic  clock,
   input  wire logic  reset,
   b64d_req_if.sink   req_bus,
   b64d_rsp_if.source rsp_bus
);

   b64d_pkg::job_type push_job, head_job;
   logic              push, pop, empty, full, accept;

   assign req_bus.ready = !full;
   assign accept        = req_bus.valid && req_bus.ready;

   b64d_front u_front (
      .clock       (clock),
      .reset       (reset),
      .accept      (accept),
      .text_char   (req_bus.text_char),
      .end_of_text (req_bus.end_of_text),
      .job         (push_job),
      .push        (push)
   );

   b64d_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_job (push_job),
      .pop      (pop),
      .head_job (head_job),
      .empty    (empty),
      .full     (full)
   );

   b64d_back u_back (
      .clock    (clock),
      .reset    (reset),
      .head_job (head_job),
      .empty    (empty),
      .pop      (pop),
      .rsp_bus  (rsp_bus)
   );

endmodule
`default_nettype wire
